// ----- src/mra_pkg.sv -----
`timescale 1ns / 1ps

package mra_pkg;

    // Field widths fixed by the interface.
    localparam int TIME_IN_BITS = 32;
    localparam int CFG_BITS     = 5;
    localparam int ROOM_OUT_BITS = 4;
    localparam int COUNT_BITS   = 20;

    localparam logic [CFG_BITS-1:0]   CFG_RESET = 5'd16;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_WAIT,
        ST_PICK,
        ST_APPLY,
        ST_COUNT,
        ST_COUNT_WAIT,
        ST_FINISH
    } t_state;

endpackage

// ----- src/meeting_room_allocator.sv -----
// Meeting room allocator. Meetings come in one beat at a time on the input channel, in
// nondecreasing start order, and each beat yields exactly one result beat with the room the
// meeting was given and the room that has taken the most bookings so far (lowest index on
// ties). A meeting takes the lowest-numbered room that is free at its start time; when every
// room is busy it takes the room that frees up first and is pushed back so that it keeps its
// duration. Busy-until times and booking counts saturate. After the result for a beat that
// has last_meeting set, all rooms return to empty. The number of rooms taking part is set
// through the configuration port (zero counts as one, values above ROOMS count as ROOMS) and
// must only be written while the block is idle. The room table lives in a single-ported
// memory that is swept once over the rooms taking part, one room per cycle, to find the
// room, then the chosen room is read and updated, and then the table is swept a second
// time to find the busiest room. The input ready is low while a meeting is worked on; a
// finished result sits in an output register, so the next meeting can be taken while it
// waits to be read. No clearing pass follows reset: each room has a valid bit that reset
// and the end of a batch clear at once.
`timescale 1ns / 1ps

module meeting_room_allocator #(
    parameter int ROOMS     = 16,
    parameter int TIME_BITS = 40
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port.
    input  logic        i_cfg_we,
    input  logic [mra_pkg::CFG_BITS-1:0] i_cfg_data,
    // Input channel.
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [mra_pkg::TIME_IN_BITS-1:0] i_start_time,
    input  logic [mra_pkg::TIME_IN_BITS-1:0] i_end_time,
    input  logic        i_last_meeting,
    // Output channel.
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [mra_pkg::ROOM_OUT_BITS-1:0] o_assigned_room,
    output logic [mra_pkg::ROOM_OUT_BITS-1:0] o_busiest_room,
    output logic        o_batch_done
);

    // Room index width, and the width of a count that can hold ROOMS itself.
    localparam int IDX_W  = (ROOMS > 1) ? $clog2(ROOMS) : 1;
    localparam int CNT_W  = $clog2(ROOMS + 1);
    // Width used for time sums and compares: wide enough for both the stored
    // times and the 32-bit start times, plus a carry bit.
    localparam int SUM_W  = ((TIME_BITS > mra_pkg::TIME_IN_BITS) ?
                             TIME_BITS : mra_pkg::TIME_IN_BITS) + 1;
    localparam int WORD_W = TIME_BITS + mra_pkg::COUNT_BITS;
    localparam logic [SUM_W-1:0] TIME_MAX = SUM_W'({TIME_BITS{1'b1}});

    // ------------------------------------------------------------------
    // Configuration register and the effective room count.
    // ------------------------------------------------------------------
    logic [mra_pkg::CFG_BITS-1:0] r_rooms_in_use;
    logic [CNT_W-1:0]             rooms_act;
    logic [CNT_W-1:0]             rooms_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rooms_in_use <= mra_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            r_rooms_in_use <= i_cfg_data;
        end
    end

    always_comb begin
        if (r_rooms_in_use == '0) begin
            rooms_act = CNT_W'(1);
        end else if (32'(r_rooms_in_use) > ROOMS) begin
            rooms_act = CNT_W'(ROOMS);
        end else begin
            rooms_act = CNT_W'(r_rooms_in_use);
        end
        rooms_last = rooms_act - CNT_W'(1);
    end

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    mra_pkg::t_state r_state;
    mra_pkg::t_state n_state;

    logic [IDX_W-1:0] r_ptr;
    logic             ptr_at_last;
    logic             in_accept;
    logic             issue;      // a sweep read goes out this cycle
    logic             mem_we;
    logic             out_free;
    logic             out_load;

    assign ptr_at_last = (CNT_W'(r_ptr) == rooms_last);
    assign out_free    = !o_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mra_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = mra_pkg::ST_SCAN;
                end
            end
            mra_pkg::ST_SCAN: begin
                if (ptr_at_last) begin
                    n_state = mra_pkg::ST_SCAN_WAIT;
                end
            end
            mra_pkg::ST_SCAN_WAIT:  n_state = mra_pkg::ST_PICK;
            mra_pkg::ST_PICK:       n_state = mra_pkg::ST_APPLY;
            mra_pkg::ST_APPLY:      n_state = mra_pkg::ST_COUNT;
            mra_pkg::ST_COUNT: begin
                if (ptr_at_last) begin
                    n_state = mra_pkg::ST_COUNT_WAIT;
                end
            end
            mra_pkg::ST_COUNT_WAIT: n_state = mra_pkg::ST_FINISH;
            mra_pkg::ST_FINISH: begin
                if (out_free) begin
                    n_state = mra_pkg::ST_IDLE;
                end
            end
            default:                n_state = mra_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = (r_state == mra_pkg::ST_IDLE);
        issue      = (r_state == mra_pkg::ST_SCAN) || (r_state == mra_pkg::ST_COUNT);
        mem_we     = (r_state == mra_pkg::ST_APPLY);
        out_load   = (r_state == mra_pkg::ST_FINISH) && out_free;
    end

    assign in_accept = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mra_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // The sweep pointer restarts at the top of each sweep.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr <= '0;
        end else if (issue && !ptr_at_last) begin
            r_ptr <= r_ptr + IDX_W'(1);
        end else begin
            r_ptr <= '0;
        end
    end

    // ------------------------------------------------------------------
    // Meeting held for the duration of the work.
    // ------------------------------------------------------------------
    logic [mra_pkg::TIME_IN_BITS-1:0] r_start;
    logic [mra_pkg::TIME_IN_BITS-1:0] r_dur;
    logic                             r_last;

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_start <= i_start_time;
            r_dur   <= (i_end_time > i_start_time) ? (i_end_time - i_start_time) : '0;
            r_last  <= i_last_meeting;
        end
    end

    // ------------------------------------------------------------------
    // Room table: busy-until time and booking count per room, one word per
    // room. A room whose valid bit is clear reads as empty.
    // ------------------------------------------------------------------
    logic [WORD_W-1:0] mem_rooms [ROOMS];
    logic [ROOMS-1:0]  r_room_vld;

    logic [IDX_W-1:0]  r_room;    // room chosen for this meeting
    logic [IDX_W-1:0]  rd_addr;
    logic [WORD_W-1:0] r_rd_word;
    logic              r_rd_vld;
    logic [IDX_W-1:0]  r_rd_idx;
    logic              r_rd_go;   // read data belongs to a sweep

    logic [TIME_BITS-1:0]           busy_eff;
    logic [mra_pkg::COUNT_BITS-1:0] cnt_eff;

    // The free room found in the final sweep cycle is only known after that
    // cycle, so the choice is made on the registered flags in the pick state.
    logic [IDX_W-1:0] room_pick;

    assign rd_addr = (r_state == mra_pkg::ST_PICK) ? room_pick : r_ptr;

    always_ff @(posedge i_clk) begin
        r_rd_word <= mem_rooms[rd_addr];
        r_rd_vld  <= r_room_vld[rd_addr];
        r_rd_idx  <= rd_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_go <= 1'b0;
        end else begin
            r_rd_go <= issue;
        end
    end

    assign busy_eff = r_rd_vld ? r_rd_word[WORD_W-1:mra_pkg::COUNT_BITS] : '0;
    assign cnt_eff  = r_rd_vld ? r_rd_word[mra_pkg::COUNT_BITS-1:0] : '0;

    // ------------------------------------------------------------------
    // First sweep: lowest free room, and the room that frees up first.
    // ------------------------------------------------------------------
    logic                 scan_data;
    logic                 r_found;
    logic [IDX_W-1:0]     r_free_idx;
    logic [TIME_BITS-1:0] r_min_busy;
    logic [IDX_W-1:0]     r_min_idx;

    assign scan_data = r_rd_go &&
                       ((r_state == mra_pkg::ST_SCAN) || (r_state == mra_pkg::ST_SCAN_WAIT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (in_accept) begin
            r_found <= 1'b0;
        end else if (scan_data && !r_found &&
                     (SUM_W'(busy_eff) <= SUM_W'(r_start))) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (scan_data && !r_found && (SUM_W'(busy_eff) <= SUM_W'(r_start))) begin
            r_free_idx <= r_rd_idx;
        end
        // Strict compare keeps the lowest index on ties.
        if (scan_data && ((r_rd_idx == '0) || (busy_eff < r_min_busy))) begin
            r_min_busy <= busy_eff;
            r_min_idx  <= r_rd_idx;
        end
        if (r_state == mra_pkg::ST_PICK) begin
            r_room <= room_pick;
        end
    end

    assign room_pick = r_found ? r_free_idx : r_min_idx;

    // ------------------------------------------------------------------
    // Update of the chosen room: one saturating add for the new busy time
    // and a saturating increment of its booking count.
    // ------------------------------------------------------------------
    logic [SUM_W-1:0]               time_base;
    logic [SUM_W-1:0]               time_sum;
    logic [TIME_BITS-1:0]           busy_new;
    logic [mra_pkg::COUNT_BITS-1:0] cnt_new;

    always_comb begin
        time_base = r_found ? SUM_W'(r_start) : SUM_W'(busy_eff);
        time_sum  = time_base + SUM_W'(r_dur);
        busy_new  = (time_sum >= TIME_MAX) ? TIME_MAX[TIME_BITS-1:0] : time_sum[TIME_BITS-1:0];
        cnt_new   = (cnt_eff == mra_pkg::COUNT_MAX) ? cnt_eff
                                                    : cnt_eff + mra_pkg::COUNT_BITS'(1);
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_rooms[r_room] <= {busy_new, cnt_new};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_room_vld <= '0;
        end else if (out_load && r_last) begin
            r_room_vld <= '0;
        end else if (mem_we) begin
            r_room_vld[r_room] <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Second sweep: busiest room after the update.
    // ------------------------------------------------------------------
    logic                           count_data;
    logic [mra_pkg::COUNT_BITS-1:0] r_best_cnt;
    logic [IDX_W-1:0]               r_best_idx;

    assign count_data = r_rd_go &&
                        ((r_state == mra_pkg::ST_COUNT) || (r_state == mra_pkg::ST_COUNT_WAIT));

    always_ff @(posedge i_clk) begin
        if (count_data && ((r_rd_idx == '0) || (cnt_eff > r_best_cnt))) begin
            r_best_cnt <= cnt_eff;
            r_best_idx <= r_rd_idx;
        end
    end

    // ------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------
    logic                               r_out_valid;
    logic [mra_pkg::ROOM_OUT_BITS-1:0]  r_out_room;
    logic [mra_pkg::ROOM_OUT_BITS-1:0]  r_out_best;
    logic                               r_out_done;
    logic [31:0]                        room_w;
    logic [31:0]                        best_w;

    assign room_w = 32'(r_room);
    assign best_w = 32'(r_best_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_room <= room_w[mra_pkg::ROOM_OUT_BITS-1:0];
            r_out_best <= best_w[mra_pkg::ROOM_OUT_BITS-1:0];
            r_out_done <= r_last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_assigned_room = r_out_room;
    assign o_busiest_room  = r_out_best;
    assign o_batch_done    = r_out_done;

endmodule

// ----- src/mra_checker.sv -----
`timescale 1ns / 1ps

module mra_checker #(
    parameter int ROOMS = 16
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input logic o_out_valid,
    input logic i_out_ready,
    input logic [mra_pkg::ROOM_OUT_BITS-1:0] o_assigned_room,
    input logic [mra_pkg::ROOM_OUT_BITS-1:0] o_busiest_room,
    input logic o_batch_done
);

    // A meeting is worked on over many cycles, so the input closes after a beat.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input ready stayed high after a beat was taken");

    // Reported rooms never lie beyond the rooms that exist.
    a_room_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((32'(o_assigned_room) < ROOMS || ROOMS >= 16) &&
                         (32'(o_busiest_room) < ROOMS || ROOMS >= 16)))
        else $error("reported room index beyond the room count");

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_assigned_room) && $stable(o_busiest_room) &&
             $stable(o_batch_done)))
        else $error("result changed while stalled");

    // Reset leaves no result pending.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && o_in_ready))
        else $error("block not idle after reset");

endmodule

bind meeting_room_allocator mra_checker #(
    .ROOMS(ROOMS)
) u_mra_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_assigned_room(o_assigned_room),
    .o_busiest_room (o_busiest_room),
    .o_batch_done   (o_batch_done)
);
